[src/masa_pkg.sv]
// ----------------------------------------------------------------------------
// Mouse aim sub-pixel accumulator package
// Shared widths, register indexes, item kinds and the configuration and
// queue entry types used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package masa_pkg;

	// Field and datapath widths.
	localparam int DELTA_W    = 16;
	localparam int GAIN_W     = 20;
	localparam int MAG_W      = 27;
	localparam int AIM_W      = 16;
	localparam int CARRY_W    = 28;
	localparam int PROD_W     = 36;
	localparam int SUM_W      = 37;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;

	// Fixed-point shifts of the two output paths.
	localparam int DIRECT_SHIFT = 12;
	localparam int SMOOTH_SHIFT = 14;

	// Saturation bounds of an aim step, at the width of a widened residual.
	localparam logic signed [CARRY_W:0] AIM_MAX = (CARRY_W+1)'((2 ** (AIM_W - 1)) - 1);
	localparam logic signed [CARRY_W:0] AIM_MIN = -(CARRY_W+1)'(2 ** (AIM_W - 1));

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(16384);
	localparam logic [MAG_W-1:0]  LIMIT_RESET = MAG_W'(67108864);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_X         = 3'd0,
		REG_GAIN_Y         = 3'd1,
		REG_DEAD_ZONE      = 3'd2,
		REG_SNAP_LIMIT     = 3'd3,
		REG_DIRECT_MODE    = 3'd4,
		REG_KEEP_FRACTION  = 3'd5,
		REG_RESIDUAL_LIMIT = 3'd6
	} cfg_reg_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [GAIN_W-1:0] gain_x;
		logic [GAIN_W-1:0] gain_y;
		logic [MAG_W-1:0]  dead_zone;
		logic [MAG_W-1:0]  snap_limit;
		logic              direct_mode;
		logic              keep_fraction;
		logic [MAG_W-1:0]  residual_limit;
	} cfg_t;

	// Classification of a request by the front end.
	typedef enum logic [1:0] {
		KIND_HOLD = 2'd0,
		KIND_IDLE = 2'd1,
		KIND_MOVE = 2'd2
	} kind_t;

	// One classified request with its scaled deltas.
	typedef struct packed {
		kind_t                    kind;
		logic                     act_x;
		logic                     act_y;
		logic signed [PROD_W-1:0] prod_x;
		logic signed [PROD_W-1:0] prod_y;
	} item_t;

endpackage

`default_nettype wire

[src/masa_front.sv]
// ----------------------------------------------------------------------------
// Mouse aim front end
// Accepts input requests, classifies them as hold, idle or move, and scales
// both deltas by their gains into a registered entry for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module masa_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire masa_pkg::cfg_t                       cfg,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [masa_pkg::DELTA_W-1:0]  delta_x,
	input  wire logic signed [masa_pkg::DELTA_W-1:0]  delta_y,
	input  wire logic                                 hold,
	output logic                                      push_valid,
	input  wire logic                                 push_ready,
	output masa_pkg::item_t                           push_item
);

	logic                               valid_s1;
	masa_pkg::item_t                    item_s1;
	masa_pkg::item_t                    item_next;
	logic signed [masa_pkg::GAIN_W:0]   gain_x_s;
	logic signed [masa_pkg::GAIN_W:0]   gain_y_s;
	logic signed [masa_pkg::SUM_W-1:0]  prod_x_full;
	logic signed [masa_pkg::SUM_W-1:0]  prod_y_full;

	// The stage takes a new request when empty or when its entry moves on.
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Gain scaling and classification.
	always_comb begin
		gain_x_s    = signed'({1'b0, cfg.gain_x});
		gain_y_s    = signed'({1'b0, cfg.gain_y});
		prod_x_full = delta_x * gain_x_s;
		prod_y_full = delta_y * gain_y_s;
		item_next.act_x  = (delta_x != '0);
		item_next.act_y  = (delta_y != '0);
		item_next.prod_x = prod_x_full[masa_pkg::PROD_W-1:0];
		item_next.prod_y = prod_y_full[masa_pkg::PROD_W-1:0];
		if (hold) begin
			item_next.kind = masa_pkg::KIND_HOLD;
		end else if (!item_next.act_x && !item_next.act_y) begin
			item_next.kind = masa_pkg::KIND_IDLE;
		end else begin
			item_next.kind = masa_pkg::KIND_MOVE;
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_next;
		end
	end

endmodule

`default_nettype wire

[src/masa_queue.sv]
// ----------------------------------------------------------------------------
// Mouse aim request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module masa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire masa_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output masa_pkg::item_t      pop_item
);

	masa_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[src/masa_back.sv]
// ----------------------------------------------------------------------------
// Mouse aim back end
// Adds the scaled deltas into the residuals and clamps them into the accumulate
// stage, then forms the aim steps, updates the residuals and loads the output
// register once the output side can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module masa_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire masa_pkg::cfg_t                      cfg,
	input  wire logic                                pop_valid,
	output logic                                     pop_ready,
	input  wire masa_pkg::item_t                     pop_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [masa_pkg::AIM_W-1:0]        aim_x,
	output logic signed [masa_pkg::AIM_W-1:0]        aim_y,
	output logic                                     aim_write
);

	// Clamp a sum to plus or minus the residual limit.
	function automatic logic signed [masa_pkg::CARRY_W-1:0] clamp_res(
		input logic signed [masa_pkg::SUM_W-1:0] sum,
		input logic [masa_pkg::MAG_W-1:0]        lim
	);
		logic signed [masa_pkg::SUM_W-1:0] pos;
		logic signed [masa_pkg::SUM_W-1:0] res;
		pos = signed'({{(masa_pkg::SUM_W - masa_pkg::MAG_W){1'b0}}, lim});
		if (sum > pos) begin
			res = pos;
		end else if (sum < -pos) begin
			res = -pos;
		end else begin
			res = sum;
		end
		return res[masa_pkg::CARRY_W-1:0];
	endfunction

	// Magnitude of a residual.
	function automatic logic [masa_pkg::CARRY_W-1:0] mag_of(
		input logic signed [masa_pkg::CARRY_W-1:0] r
	);
		return r[masa_pkg::CARRY_W-1] ? masa_pkg::CARRY_W'(-r) : masa_pkg::CARRY_W'(r);
	endfunction

	// Residual shifted toward zero and saturated to an aim step.
	function automatic logic signed [masa_pkg::AIM_W-1:0] trunc_step(
		input logic signed [masa_pkg::CARRY_W-1:0] r,
		input int                                  sh
	);
		logic [masa_pkg::CARRY_W-1:0]    q;
		logic signed [masa_pkg::CARRY_W:0] v;
		logic signed [masa_pkg::CARRY_W:0] s;
		q = mag_of(r) >> sh;
		v = r[masa_pkg::CARRY_W-1] ? -signed'({1'b0, q}) : signed'({1'b0, q});
		if (v > masa_pkg::AIM_MAX) begin
			s = masa_pkg::AIM_MAX;
		end else if (v < masa_pkg::AIM_MIN) begin
			s = masa_pkg::AIM_MIN;
		end else begin
			s = v;
		end
		return s[masa_pkg::AIM_W-1:0];
	endfunction

	// Smoothed step of one axis: deadzone, unit snap or shifted residual.
	function automatic logic signed [masa_pkg::AIM_W-1:0] smooth_step(
		input logic signed [masa_pkg::CARRY_W-1:0] r,
		input logic [masa_pkg::MAG_W-1:0]          dz,
		input logic [masa_pkg::MAG_W-1:0]          snap
	);
		logic [masa_pkg::CARRY_W-1:0]        m;
		logic signed [masa_pkg::AIM_W-1:0]   st;
		m = mag_of(r);
		if (m < masa_pkg::CARRY_W'(snap)) begin
			if (m < masa_pkg::CARRY_W'(dz)) begin
				st = '0;
			end else if (r[masa_pkg::CARRY_W-1]) begin
				st = -masa_pkg::AIM_W'(1);
			end else begin
				st = masa_pkg::AIM_W'(1);
			end
		end else begin
			st = trunc_step(r, masa_pkg::SMOOTH_SHIFT);
		end
		return st;
	endfunction

	// Residual less the emitted step scaled back up.
	function automatic logic signed [masa_pkg::CARRY_W-1:0] take_step(
		input logic signed [masa_pkg::CARRY_W-1:0] r,
		input logic signed [masa_pkg::AIM_W-1:0]   st,
		input int                                  sh
	);
		logic signed [masa_pkg::SUM_W-1:0] wide;
		wide = masa_pkg::SUM_W'(r) - (masa_pkg::SUM_W'(st) <<< sh);
		return wide[masa_pkg::CARRY_W-1:0];
	endfunction

	logic                                       acc_valid_s1;
	masa_pkg::kind_t                            kind_s1;
	logic                                       act_x_s1;
	logic                                       act_y_s1;
	logic signed [masa_pkg::CARRY_W-1:0]        res_x_s1;
	logic signed [masa_pkg::CARRY_W-1:0]        res_y_s1;
	logic signed [masa_pkg::CARRY_W-1:0]        carry_x_q;
	logic signed [masa_pkg::CARRY_W-1:0]        carry_y_q;
	logic signed [masa_pkg::SUM_W-1:0]          sum_x;
	logic signed [masa_pkg::SUM_W-1:0]          sum_y;
	logic                                       emit;
	logic signed [masa_pkg::AIM_W-1:0]          step_x;
	logic signed [masa_pkg::AIM_W-1:0]          step_y;
	logic signed [masa_pkg::CARRY_W-1:0]        next_x;
	logic signed [masa_pkg::CARRY_W-1:0]        next_y;
	logic [masa_pkg::CARRY_W-1:0]               gate_x;
	logic [masa_pkg::CARRY_W-1:0]               gate_y;
	logic                                       in_dead;
	logic                                       out_valid_q;
	logic signed [masa_pkg::AIM_W-1:0]          aim_x_q;
	logic signed [masa_pkg::AIM_W-1:0]          aim_y_q;
	logic                                       aim_write_q;

	// A request enters only after the previous one has updated the residuals.
	assign pop_ready = !acc_valid_s1;
	assign emit      = acc_valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign aim_x     = aim_x_q;
	assign aim_y     = aim_y_q;
	assign aim_write = aim_write_q;

	// Accumulate stage: add the scaled deltas.
	always_comb begin
		sum_x = masa_pkg::SUM_W'(carry_x_q) + masa_pkg::SUM_W'(pop_item.prod_x);
		sum_y = masa_pkg::SUM_W'(carry_y_q) + masa_pkg::SUM_W'(pop_item.prod_y);
	end

	// Step stage: aim steps and updated residuals.
	always_comb begin
		gate_x  = act_x_s1 ? mag_of(res_x_s1) : '0;
		gate_y  = act_y_s1 ? mag_of(res_y_s1) : '0;
		in_dead = (gate_x < masa_pkg::CARRY_W'(cfg.dead_zone))
			&& (gate_y < masa_pkg::CARRY_W'(cfg.dead_zone));
		step_x  = '0;
		step_y  = '0;
		next_x  = res_x_s1;
		next_y  = res_y_s1;
		if (cfg.direct_mode) begin
			if (act_x_s1) begin
				step_x = trunc_step(res_x_s1, masa_pkg::DIRECT_SHIFT);
			end
			if (act_y_s1) begin
				step_y = trunc_step(res_y_s1, masa_pkg::DIRECT_SHIFT);
			end
			next_x = take_step(res_x_s1, step_x, masa_pkg::DIRECT_SHIFT);
			next_y = take_step(res_y_s1, step_y, masa_pkg::DIRECT_SHIFT);
		end else if (!in_dead) begin
			if (act_x_s1) begin
				step_x = smooth_step(res_x_s1, cfg.dead_zone, cfg.snap_limit);
			end
			if (act_y_s1) begin
				step_y = smooth_step(res_y_s1, cfg.dead_zone, cfg.snap_limit);
			end
			next_x = take_step(res_x_s1, step_x, masa_pkg::SMOOTH_SHIFT);
			next_y = take_step(res_y_s1, step_y, masa_pkg::SMOOTH_SHIFT);
		end
	end

	// Control state: accumulate stage, residuals and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_s1 <= 1'b0;
			carry_x_q    <= '0;
			carry_y_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				acc_valid_s1 <= 1'b1;
			end else if (emit) begin
				acc_valid_s1 <= 1'b0;
			end
			if (emit) begin
				unique case (kind_s1)
					masa_pkg::KIND_HOLD: begin
						carry_x_q <= '0;
						carry_y_q <= '0;
					end
					masa_pkg::KIND_IDLE: begin
						if (!cfg.keep_fraction) begin
							carry_x_q <= '0;
							carry_y_q <= '0;
						end
					end
					masa_pkg::KIND_MOVE: begin
						carry_x_q <= cfg.keep_fraction ? next_x : '0;
						carry_y_q <= cfg.keep_fraction ? next_y : '0;
					end
					default: begin
						carry_x_q <= carry_x_q;
						carry_y_q <= carry_y_q;
					end
				endcase
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Accumulate stage payload.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			kind_s1  <= pop_item.kind;
			act_x_s1 <= pop_item.act_x;
			act_y_s1 <= pop_item.act_y;
			res_x_s1 <= clamp_res(sum_x, cfg.residual_limit);
			res_y_s1 <= clamp_res(sum_y, cfg.residual_limit);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if ((kind_s1 == masa_pkg::KIND_MOVE) && ((step_x != '0) || (step_y != '0))) begin
				aim_x_q     <= step_x;
				aim_y_q     <= step_y;
				aim_write_q <= 1'b1;
			end else begin
				aim_x_q     <= '0;
				aim_y_q     <= '0;
				aim_write_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[src/mouse_aim_subpixel_accumulator.sv]
// ----------------------------------------------------------------------------
// Mouse aim sub-pixel accumulator
// Scales per-frame mouse deltas by Q14 gains, accumulates clamped residuals
// per axis and emits integer aim steps in direct or smoothed mode.
//
// Channel   Direction  Contents
// s_axis    in         tdata: delta_x, delta_y; tuser: hold
// m_axis    out        tdata: aim_x, aim_y; tuser: aim_write
// cfg       in         cfg_we, cfg_index, cfg_wdata register writes
//
// The back end takes a new request only after the previous one has updated the
// residuals: the residual feedback loop spans the accumulate-and-clamp stage and
// the step-and-subtract stage. A two-entry queue lets the front end keep
// accepting while the back end or the output side stalls. Reset clears the
// queue, the residuals and all valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_aim_subpixel_accumulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [31:0]                          s_axis_tdata,  // delta_x, delta_y
	input  wire logic [0:0]                           s_axis_tuser,  // hold
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic [31:0]                               m_axis_tdata,  // aim_x, aim_y
	output logic [0:0]                                m_axis_tuser,  // aim_write
	input  wire logic                                 cfg_we,
	input  wire logic [masa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [masa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	masa_pkg::cfg_t                      cfg_q;
	logic                                push_valid;
	logic                                push_ready;
	masa_pkg::item_t                     push_item;
	logic                                pop_valid;
	logic                                pop_ready;
	masa_pkg::item_t                     pop_item;
	logic signed [masa_pkg::AIM_W-1:0]   aim_x;
	logic signed [masa_pkg::AIM_W-1:0]   aim_y;
	logic                                aim_write;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_x         <= masa_pkg::GAIN_RESET;
			cfg_q.gain_y         <= masa_pkg::GAIN_RESET;
			cfg_q.dead_zone      <= '0;
			cfg_q.snap_limit     <= '0;
			cfg_q.direct_mode    <= 1'b1;
			cfg_q.keep_fraction  <= 1'b1;
			cfg_q.residual_limit <= masa_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (masa_pkg::cfg_reg_t'(cfg_index))
				masa_pkg::REG_GAIN_X:         cfg_q.gain_x <= cfg_wdata[masa_pkg::GAIN_W-1:0];
				masa_pkg::REG_GAIN_Y:         cfg_q.gain_y <= cfg_wdata[masa_pkg::GAIN_W-1:0];
				masa_pkg::REG_DEAD_ZONE:      cfg_q.dead_zone <= cfg_wdata[masa_pkg::MAG_W-1:0];
				masa_pkg::REG_SNAP_LIMIT:     cfg_q.snap_limit <= cfg_wdata[masa_pkg::MAG_W-1:0];
				masa_pkg::REG_DIRECT_MODE:    cfg_q.direct_mode <= cfg_wdata[0];
				masa_pkg::REG_KEEP_FRACTION:  cfg_q.keep_fraction <= cfg_wdata[0];
				masa_pkg::REG_RESIDUAL_LIMIT: cfg_q.residual_limit <= cfg_wdata[masa_pkg::MAG_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front end: accept, classify and scale.
	masa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.delta_x    (signed'(s_axis_tdata[15:0])),
		.delta_y    (signed'(s_axis_tdata[31:16])),
		.hold       (s_axis_tuser[0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue between the two ends.
	masa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: accumulate, emit and update residuals.
	masa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.aim_x      (aim_x),
		.aim_y      (aim_y),
		.aim_write  (aim_write)
	);

	assign m_axis_tdata = {aim_y, aim_x};
	assign m_axis_tuser = aim_write;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse aim sub-pixel accumulator testbench
// Sends frames of mouse deltas through the request stream, keeps a shadow of
// the register file and of the per-axis residuals, and checks every aim step
// that leaves the block against the predicted one, in order.
// Directed frames come first, then several phases of random frames, each
// under new register settings written while the block is idle.
// ----------------------------------------------------------------------------

import masa_pkg::*;

// One predicted aim result, laid out as it leaves the block.
typedef struct packed {
	logic                    write;
	logic signed [AIM_W-1:0] y;
	logic signed [AIM_W-1:0] x;
} aim_t;

// Shadow of the accumulator with its queue of aim steps still to arrive.
class aim_tracker;
	cfg_t                       cfg;
	logic signed [CARRY_W-1:0]  carry_x;
	logic signed [CARRY_W-1:0]  carry_y;
	aim_t                       expected_aims[$];
	int unsigned                errors;

	function new();
		cfg.gain_x         = GAIN_RESET;
		cfg.gain_y         = GAIN_RESET;
		cfg.dead_zone      = '0;
		cfg.snap_limit     = '0;
		cfg.direct_mode    = 1'b1;
		cfg.keep_fraction  = 1'b1;
		cfg.residual_limit = LIMIT_RESET;
		carry_x            = '0;
		carry_y            = '0;
		errors             = 0;
	endfunction

	// Mirror a register write into the shadow settings.
	function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_GAIN_X:         cfg.gain_x = value[GAIN_W-1:0];
			REG_GAIN_Y:         cfg.gain_y = value[GAIN_W-1:0];
			REG_DEAD_ZONE:      cfg.dead_zone = value[MAG_W-1:0];
			REG_SNAP_LIMIT:     cfg.snap_limit = value[MAG_W-1:0];
			REG_DIRECT_MODE:    cfg.direct_mode = value[0];
			REG_KEEP_FRACTION:  cfg.keep_fraction = value[0];
			REG_RESIDUAL_LIMIT: cfg.residual_limit = value[MAG_W-1:0];
			default: ;
		endcase
	endfunction

	function longint clamp_to(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Arithmetic shift that rounds toward zero for both signs.
	function longint trunc_shift(longint v, int sh);
		if (v >= 0)
			return v >>> sh;
		return -((-v) >>> sh);
	endfunction

	function longint sat_step(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Smoothed step of one axis: deadzone, unit snap, or plain shift.
	function longint smooth_step(longint r);
		longint a;
		a = (r < 0) ? -r : r;
		if (a < longint'(cfg.snap_limit)) begin
			if (a < longint'(cfg.dead_zone))
				return 0;
			return (r < 0) ? -1 : 1;
		end
		return sat_step(trunc_shift(r, SMOOTH_SHIFT));
	endfunction

	// Predict the aim step caused by one accepted frame.
	function void note_frame(input logic signed [DELTA_W-1:0] dx,
			input logic signed [DELTA_W-1:0] dy, input logic hold);
		longint rx, ry, ox, oy, ax, ay, lim;
		aim_t   res;
		res = '0;
		ox  = 0;
		oy  = 0;
		lim = longint'(cfg.residual_limit);
		if (hold) begin
			carry_x = '0;
			carry_y = '0;
		end else if (dx == 0 && dy == 0) begin
			if (!cfg.keep_fraction) begin
				carry_x = '0;
				carry_y = '0;
			end
		end else begin
			rx = clamp_to(longint'(carry_x) + longint'(dx) * longint'(cfg.gain_x), lim);
			ry = clamp_to(longint'(carry_y) + longint'(dy) * longint'(cfg.gain_y), lim);
			if (cfg.direct_mode) begin
				if (dx != 0)
					ox = sat_step(trunc_shift(rx, DIRECT_SHIFT));
				if (dy != 0)
					oy = sat_step(trunc_shift(ry, DIRECT_SHIFT));
				rx = rx - ox * (longint'(1) << DIRECT_SHIFT);
				ry = ry - oy * (longint'(1) << DIRECT_SHIFT);
			end else begin
				// An axis without movement counts as zero for the deadzone.
				ax = (dx == 0) ? 0 : ((rx < 0) ? -rx : rx);
				ay = (dy == 0) ? 0 : ((ry < 0) ? -ry : ry);
				if (!(ax < longint'(cfg.dead_zone) && ay < longint'(cfg.dead_zone))) begin
					if (dx != 0)
						ox = smooth_step(rx);
					if (dy != 0)
						oy = smooth_step(ry);
					rx = rx - ox * (longint'(1) << SMOOTH_SHIFT);
					ry = ry - oy * (longint'(1) << SMOOTH_SHIFT);
				end
			end
			carry_x = cfg.keep_fraction ? rx[CARRY_W-1:0] : '0;
			carry_y = cfg.keep_fraction ? ry[CARRY_W-1:0] : '0;
			if (ox != 0 || oy != 0) begin
				res.x     = ox[AIM_W-1:0];
				res.y     = oy[AIM_W-1:0];
				res.write = 1'b1;
			end
		end
		expected_aims.push_back(res);
	endfunction

	// Compare one accepted aim result with the oldest prediction.
	function void check_aim(logic [31:0] tdata, logic [0:0] tuser);
		aim_t                    want;
		logic signed [AIM_W-1:0] got_x;
		logic signed [AIM_W-1:0] got_y;
		got_x = tdata[AIM_W-1:0];
		got_y = tdata[2*AIM_W-1:AIM_W];
		if (expected_aims.size() == 0) begin
			$error("aim result with none predicted: tdata=%h tuser=%b", tdata, tuser);
			errors++;
			return;
		end
		want = expected_aims.pop_front();
		if (got_x !== want.x) begin
			$error("aim_x: expected %0d, actual %0d", want.x, got_x);
			errors++;
		end
		if (got_y !== want.y) begin
			$error("aim_y: expected %0d, actual %0d", want.y, got_y);
			errors++;
		end
		if (tuser[0] !== want.write) begin
			$error("aim_write: expected %0b, actual %0b", want.write, tuser[0]);
			errors++;
		end
	endfunction
endclass

module tb;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;   // delta_x, delta_y
	logic [0:0]            s_axis_tuser = '0;   // hold
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;        // aim_x, aim_y
	logic [0:0]            m_axis_tuser;        // aim_write
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	aim_tracker tracker;
	bit         quiet = 1'b0;
	cfg_t       setting;
	int         phase;

	mouse_aim_subpixel_accumulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Check every aim result that the output side accepts.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_aim(m_axis_tdata, m_axis_tuser);
	end

	// The output side stalls in short random bursts until the quiet phase.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one frame as a request and note it once it is accepted.
	task automatic send_frame(input logic signed [DELTA_W-1:0] dx,
			input logic signed [DELTA_W-1:0] dy, input logic hold);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dy, dx};
		s_axis_tuser  <= hold;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_frame(dx, dy, hold);
		@(negedge clk);
	endtask

	// Stop requests and wait until every predicted aim step has arrived.
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		while (tracker.expected_aims.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		tracker.set_reg(idx, value);
	endtask

	// Write the whole register file; the block must be idle.
	task automatic program_regs(input cfg_t c);
		put_reg(REG_GAIN_X, CFG_DATA_W'(c.gain_x));
		put_reg(REG_GAIN_Y, CFG_DATA_W'(c.gain_y));
		put_reg(REG_DEAD_ZONE, CFG_DATA_W'(c.dead_zone));
		put_reg(REG_SNAP_LIMIT, CFG_DATA_W'(c.snap_limit));
		put_reg(REG_DIRECT_MODE, CFG_DATA_W'(c.direct_mode));
		put_reg(REG_KEEP_FRACTION, CFG_DATA_W'(c.keep_fraction));
		put_reg(REG_RESIDUAL_LIMIT, CFG_DATA_W'(c.residual_limit));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return {GAIN_W{1'b1}};
			2: return GAIN_W'($urandom);
			3: return GAIN_W'($urandom_range(0, 4096));
			default: return GAIN_W'($urandom_range(8192, 32768));
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] pick_mag(input int unsigned typical);
		case ($urandom_range(0, 6))
			0: return '0;
			1: return {MAG_W{1'b1}};
			2: return MAG_W'($urandom);
			default: return MAG_W'($urandom_range(0, typical));
		endcase
	endfunction

	// Mostly small movements, where deadzone and snap matter, plus extremes.
	function automatic logic signed [DELTA_W-1:0] pick_delta();
		case ($urandom_range(0, 19))
			0, 1, 2, 3: return '0;
			4, 5, 6, 7, 8, 9, 10, 11: return DELTA_W'($signed($urandom_range(0, 16)) - 8);
			12, 13, 14: return DELTA_W'($signed($urandom_range(0, 600)) - 300);
			15, 16, 17: return DELTA_W'($urandom);
			18: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
		endcase
	endfunction

	function automatic cfg_t random_setting();
		cfg_t c;
		c.gain_x         = pick_gain();
		c.gain_y         = pick_gain();
		c.dead_zone      = pick_mag(40000);
		c.snap_limit     = pick_mag(120000);
		c.direct_mode    = 1'($urandom_range(0, 1));
		c.keep_fraction  = ($urandom_range(0, 3) != 0);
		c.residual_limit = pick_mag(1 << 26);
		return c;
	endfunction

	initial begin
		tracker = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: direct path, unity gain, residuals carried.
		send_frame(16'sd1, 16'sd0, 1'b0);
		send_frame(16'sd0, -16'sd1, 1'b0);
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd5, 16'sd5, 1'b1);
		send_frame(-16'sd1, -16'sd1, 1'b0);
		send_frame(16'sh5555, 16'shaaaa, 1'b0);
		send_frame(16'shaaaa, 16'sh5555, 1'b1);
		drain(4);

		// Smoothed path: deadzone, unit snap and shifted steps.
		setting = '{gain_x: 20'd1000, gain_y: 20'd1000, dead_zone: 27'd3000,
			snap_limit: 27'd20000, direct_mode: 1'b0, keep_fraction: 1'b1,
			residual_limit: LIMIT_RESET};
		program_regs(setting);
		send_frame(16'sd1, 16'sd0, 1'b0);
		send_frame(16'sd2, 16'sd0, 1'b0);
		send_frame(-16'sd1, 16'sd3, 1'b0);
		send_frame(16'sd30, -16'sd30, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd1, 16'sd1, 1'b1);
		drain(4);

		// Largest gains, bounds and thresholds, fractions dropped.
		setting = '{gain_x: '1, gain_y: '1, dead_zone: '1, snap_limit: '1,
			direct_mode: 1'b0, keep_fraction: 1'b0, residual_limit: '1};
		program_regs(setting);
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sd1, 16'sd0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0);
		drain(4);

		// Zero gains and a zero residual bound on the direct path.
		setting = '{gain_x: '0, gain_y: '0, dead_zone: '0, snap_limit: '0,
			direct_mode: 1'b1, keep_fraction: 1'b0, residual_limit: '0};
		program_regs(setting);
		send_frame(16'sh7fff, 16'sh7fff, 1'b0);
		send_frame(16'sh8000, 16'sd0, 1'b0);
		drain(4);

		// Random phases; the last one runs without any idling.
		for (phase = 0; phase < 8; phase++) begin
			quiet = (phase == 7);
			setting = random_setting();
			program_regs(setting);
			repeat (75) begin
				if ($urandom_range(0, 11) == 0)
					send_frame(DELTA_W'($urandom), DELTA_W'($urandom), 1'b1);
				else
					send_frame(pick_delta(), pick_delta(), 1'b0);
			end
			drain(4);
		end

		drain(8);
		if (tracker.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
